// File: rtl/core/bolq_pkg.sv
// ----------------------------------------------------------------------------
// bolq_pkg
// shared codes for the bounded ordered list queue
// ----------------------------------------------------------------------------
package bolq_pkg;
  localparam logic [2:0] FN_ENQ = 3'd0;
  localparam logic [2:0] FN_DEQ = 3'd1;
  localparam logic [2:0] FN_INS_AFTER = 3'd2;
  localparam logic [2:0] FN_INS_BEFORE = 3'd3;
  localparam logic [2:0] FN_LIST_FWD = 3'd4;
  localparam logic [2:0] FN_LIST_REV = 3'd5;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;
  localparam logic [4:0] LIMIT_RESET = 5'd4;
  localparam logic REG_LIMIT = 1'b0;
endpackage

// File: rtl/core/bounded_ordered_list_queue_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_queue_top
// ordered list of name keys with enqueue, dequeue, insert and listing
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; busy stays high
// until the cycle that shows the last result of that request with valid
// high, and drops in that cycle. results cannot be held off by the receiver.
// keys live in one ram with a registered read; the list is kept packed from
// position 0 (front). every visited entry is first read, then used:
//   enqueue, empty or refused requests: no entry is visited
//   dequeue: visits every entry and shifts it toward the front
//   insert: searches from the front for the target, then moves each entry
//     behind the insert point up one slot, then writes the key; not found ends at the last entry
//   listing: one result per visited entry, from the front or from the back
// the limit register is written over the apb port, reset value 4; reset clears
// the count and the control state, the ram contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_ordered_list_queue_top
  import bolq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [63:0] new_name,
  input  logic [63:0] target_name,
  output logic        valid,
  output logic [1:0]  status,
  output logic [63:0] out_name,
  output logic [4:0]  entry_count,
  output logic [4:0]  free_slots,
  output logic        last
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEQ = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [4:0] limit;
  logic [CW-1:0] count, eff;
  logic [2:0] state;
  logic [2:0] fn;
  logic [KEY_BITS-1:0] nkey, tkey;
  logic [CW-1:0] idx, pos;
  logic phase;
  logic [1:0] st_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_BITS-1:0] wdata, rdata;
  logic accept, full;

  assign pready = 1'b1;
  assign prdata = {27'd0, limit};
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    if ({{(CW > 5 ? CW-5 : 0){1'b0}}, limit} >= CAP) eff = CAP;
    else eff = CW'(limit);
  end
  assign full = (count >= eff);

  logic [CW-1:0] cnt_now;
  assign cnt_now = count;

  bolq_ram #(.WIDTH(KEY_BITS), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) limit <= LIMIT_RESET;
    else if (psel && penable && pwrite && paddr[2] == REG_LIMIT) limit <= pwdata[4:0];
  end

  // control
  always_ff @(posedge clk) begin
    we <= 1'b0;
    valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fn <= func;
            nkey <= new_name[KEY_BITS-1:0];
            tkey <= target_name[KEY_BITS-1:0];
            idx <= '0;
            phase <= 1'b0;
            raddr <= '0;
            st_r <= ST_OK;
            out_name <= '0;
            state <= S_DONE;
            priority case (1'b1)
              func == FN_ENQ: begin
                if (full) st_r <= ST_FULL;
                else begin
                  we <= 1'b1; waddr <= AW'(count); wdata <= new_name[KEY_BITS-1:0];
                  count <= count + 1'b1;
                end
              end
              func == FN_DEQ: begin
                if (count == 0) st_r <= ST_EMPTY;
                else begin
                  state <= S_DEQ; raddr <= '0;
                end
              end
              func == FN_INS_AFTER || func == FN_INS_BEFORE: begin
                if (count == 0) st_r <= ST_EMPTY;
                else if (full) st_r <= ST_FULL;
                else state <= S_SRCH;
              end
              func == FN_LIST_FWD || func == FN_LIST_REV: begin
                if (count == 0) st_r <= ST_EMPTY;
                else begin
                  state <= S_LIST;
                  raddr <= (func == FN_LIST_FWD) ? '0 : AW'(count - 1'b1);
                end
              end
              default: ;
            endcase
          end
        end
        S_DEQ: begin
          // phase 0: data for idx ready next cycle; phase 1: rdata holds entry idx
          if (!phase) phase <= 1'b1;
          else begin
            if (idx == 0) out_name <= rdata;
            else begin
              we <= 1'b1; waddr <= AW'(idx - 1'b1); wdata <= rdata;
            end
            if (idx + 1'b1 == count) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
              phase <= 1'b0;
            end
          end
        end
        S_SRCH: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (rdata == tkey) begin
              pos <= (fn == FN_INS_AFTER) ? idx + 1'b1 : idx;
              idx <= count;
              raddr <= AW'(count - 1'b1);
              state <= S_SHIFT;
            end else if (idx + 1'b1 == count) begin
              st_r <= ST_NOTFOUND;
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
              raddr <= AW'(idx + 1'b1);
            end
          end
        end
        S_SHIFT: begin
          // idx is the slot to fill; moves entry idx-1 up until idx == pos
          if (idx == pos) begin
            we <= 1'b1; waddr <= AW'(pos); wdata <= nkey;
            count <= count + 1'b1;
            state <= S_DONE;
          end else if (!phase) phase <= 1'b1;
          else begin
            we <= 1'b1; waddr <= AW'(idx); wdata <= rdata;
            idx <= idx - 1'b1;
            raddr <= AW'(idx - 2'd2);
            phase <= 1'b0;
          end
        end
        S_LIST: begin
          if (!phase) phase <= 1'b1;
          else begin
            valid <= 1'b1;
            st_r <= ST_OK;
            out_name <= rdata;
            last <= (idx + 1'b1 == count);
            if (idx + 1'b1 == count) state <= S_IDLE;
            else begin
              idx <= idx + 1'b1;
              raddr <= (fn == FN_LIST_FWD) ? AW'(idx + 1'b1) : AW'(count - idx - 2'd2);
              phase <= 1'b0;
            end
          end
        end
        S_DONE: begin
          valid <= 1'b1;
          last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = st_r;
  assign entry_count = 5'(cnt_now);
  assign free_slots = (eff > count) ? 5'(eff - count) : 5'd0;

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("count above capacity");
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> state == S_IDLE)
    else $error("final result while still busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken without going busy");
endmodule

// File: rtl/core/bolq_ram.sv
// ----------------------------------------------------------------------------
// bolq_ram
// simple dual port synchronous ram (one write port, one read port), registered read
// ----------------------------------------------------------------------------
module bolq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives list requests with random gaps, predicts every result from a local
// model of the ordered list and compares each strobed result in order
// ----------------------------------------------------------------------------
module testbench
  import bolq_pkg::*;
;

  typedef struct packed {
    logic [2:0]  fn;
    logic [63:0] nkey;
    logic [63:0] tkey;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] name;
    logic [4:0]  cnt;
    logic [4:0]  fre;
    logic        lst;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = '0;
  logic [63:0] new_name = '0;
  logic [63:0] target_name = '0;
  logic        valid;
  logic [1:0]  status;
  logic [63:0] out_name;
  logic [4:0]  entry_count;
  logic [4:0]  free_slots;
  logic        last;

  bounded_ordered_list_queue_top i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t        pending_reqs[$];
  res_t        expected_results[$];
  logic [63:0] list_keys[16];
  int          list_count;
  int          limit_value;
  int          errors;
  int          cycles;
  int          gap;
  logic [63:0] key_pool[8];
  logic        busy_at_edge = 1'b1;

  function automatic logic [4:0] free_now();
    int lim;
    lim = limit_value < 16 ? limit_value : 16;
    return lim > list_count ? 5'(lim - list_count) : 5'd0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [63:0] nm, logic lst);
    res_t r;
    r.st = st;
    r.name = nm;
    r.cnt = 5'(list_count);
    r.fre = free_now();
    r.lst = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void put_key(int pos, logic [63:0] k);
    for (int i = list_count; i > pos; i--) list_keys[i] = list_keys[i - 1];
    list_keys[pos] = k;
    list_count++;
  endfunction

  function automatic void predict_list_op(req_t q);
    int lim;
    int idx;
    logic [63:0] v;
    lim = limit_value < 16 ? limit_value : 16;
    case (q.fn)
      FN_ENQ: begin
        if (list_count >= lim) push_result(ST_FULL, '0, 1'b1);
        else begin
          put_key(list_count, q.nkey);
          push_result(ST_OK, '0, 1'b1);
        end
      end
      FN_DEQ: begin
        if (list_count == 0) push_result(ST_EMPTY, '0, 1'b1);
        else begin
          v = list_keys[0];
          for (int i = 1; i < list_count; i++) list_keys[i - 1] = list_keys[i];
          list_count--;
          push_result(ST_OK, v, 1'b1);
        end
      end
      FN_INS_AFTER, FN_INS_BEFORE: begin
        if (list_count == 0) push_result(ST_EMPTY, '0, 1'b1);
        else if (list_count >= lim) push_result(ST_FULL, '0, 1'b1);
        else begin
          idx = -1;
          for (int i = list_count - 1; i >= 0; i--) if (list_keys[i] == q.tkey) idx = i;
          if (idx < 0) push_result(ST_NOTFOUND, '0, 1'b1);
          else begin
            put_key(q.fn == FN_INS_AFTER ? idx + 1 : idx, q.nkey);
            push_result(ST_OK, '0, 1'b1);
          end
        end
      end
      FN_LIST_FWD, FN_LIST_REV: begin
        if (list_count == 0) push_result(ST_EMPTY, '0, 1'b1);
        else
          for (int i = 0; i < list_count; i++)
            push_result(ST_OK, list_keys[q.fn == FN_LIST_FWD ? i : list_count - 1 - i],
                        i + 1 == list_count);
      end
      default: push_result(ST_OK, '0, 1'b1);
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // driver: one request in flight on the start line
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        start <= 1'b0;
        gap <= pick_gap();
      end else if (!start && pending_reqs.size() > 0) begin
        if (gap > 0) gap <= gap - 1;
        else begin
          func <= pending_reqs[0].fn;
          new_name <= pending_reqs[0].nkey;
          target_name <= pending_reqs[0].tkey;
          predict_list_op(pending_reqs.pop_front());
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) busy_at_edge <= busy;

  // monitor
  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result st=%0d name=%h", $time, status, out_name);
        errors <= errors + 1;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st || out_name !== e.name || entry_count !== e.cnt ||
            free_slots !== e.fre || last !== e.lst) begin
          $display("%0t expected st=%0d name=%h cnt=%0d free=%0d last=%0b", $time,
                   e.st, e.name, e.cnt, e.fre, e.lst);
          $display("%0t actual   st=%0d name=%h cnt=%0d free=%0d last=%0b", $time,
                   status, out_name, entry_count, free_slots, last);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > 400000) begin
      $display("bounded_ordered_list_queue_top: mismatch");
      $finish;
    end
  end

  task automatic add_req(logic [2:0] f, logic [63:0] n, logic [63:0] t);
    req_t q;
    q.fn = f;
    q.nkey = n;
    q.tkey = t;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_LIMIT);
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_value = v;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_key();
    return key_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    int settings[5];
    errors = 0;
    cycles = 0;
    gap = 0;
    list_count = 0;
    limit_value = LIMIT_RESET;
    settings = '{16, 1, 31, 7, 0};
    for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset limit of four
    add_req(FN_DEQ, '0, '0);
    add_req(FN_LIST_FWD, '0, '0);
    add_req(FN_INS_AFTER, 64'h1, 64'h1);
    add_req(FN_ENQ, '0, '0);
    add_req(FN_ENQ, '1, '1);
    add_req(FN_INS_BEFORE, 64'h5555_aaaa_5555_aaaa, '1);
    add_req(FN_INS_AFTER, 64'haaaa_5555_aaaa_5555, '0);
    add_req(FN_INS_AFTER, 64'h7, 64'h1234);
    add_req(FN_ENQ, 64'h8, '0);
    add_req(FN_ENQ, 64'h9, '0);
    add_req(FN_INS_BEFORE, 64'h9, '0);
    add_req(FN_LIST_FWD, '0, '0);
    add_req(FN_LIST_REV, '0, '0);
    add_req(3'd6, '1, '1);
    add_req(3'd7, '1, '1);
    add_req(FN_DEQ, '0, '0);
    add_req(FN_LIST_REV, '0, '0);
    drain();

    foreach (settings[s]) begin
      write_limit(settings[s]);
      for (int n = 0; n < 30; n++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) add_req(FN_ENQ, $urandom_range(0, 3) == 0 ? rand_key() : pool_key(), rand_key());
        else if (r < 45) add_req(FN_DEQ, rand_key(), rand_key());
        else if (r < 60) add_req(FN_INS_AFTER, pool_key(),
                                 $urandom_range(0, 4) == 0 ? rand_key() : pool_key());
        else if (r < 75) add_req(FN_INS_BEFORE, pool_key(),
                                 $urandom_range(0, 4) == 0 ? rand_key() : pool_key());
        else if (r < 86) add_req(FN_LIST_FWD, rand_key(), rand_key());
        else if (r < 97) add_req(FN_LIST_REV, rand_key(), rand_key());
        else add_req(3'($urandom_range(6, 7)), rand_key(), rand_key());
      end
      drain();
    end

    if (errors == 0) begin
      $display("bounded_ordered_list_queue_top: match");
    end else begin
      $display("bounded_ordered_list_queue_top: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/bolq_pkg.sv
rtl/core/bolq_ram.sv
rtl/core/bounded_ordered_list_queue_top.sv
tb/testbench.sv
